// ===== hw/rtl/dts_pkg.sv =====
// Package for the four-table discrete sampler.
// Holds field widths, command codes and default sizes; no dependencies.
package dts_pkg;

  localparam int CMD_W       = 2;
  localparam int WORD_W      = 32;
  localparam int CAT_W       = 6;
  localparam int BYTE_W      = 8;
  localparam int NUM_TABLES  = 4;
  localparam int TBL_W       = 2;

  localparam int DEF_CATEGORIES  = 64;
  localparam int DEF_TABLE_DEPTH = 16384;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_LOAD   = 2'd1,
    CMD_SAMPLE = 2'd2
  } dts_cmd_t;

endpackage

// ===== hw/rtl/dts_if.sv =====
// Handshake channels of the discrete sampler: command beats in, sample beats out.
// Depends on dts_pkg for the field widths.
interface dts_in_if;
  import dts_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [WORD_W-1:0] weight;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output cmd, output weight, output random_word, input ready);
  modport sink   (input valid, input cmd, input weight, input random_word, output ready);
endinterface

interface dts_out_if;
  import dts_pkg::*;
  logic             valid;
  logic             ready;
  logic [CAT_W-1:0] category;
  logic             out_of_range;

  modport source (output valid, output category, output out_of_range, input ready);
  modport sink   (input valid, input category, input out_of_range, output ready);
endinterface

// ===== hw/rtl/discrete_table_sampler_core.sv =====
// Sample: one beat per cycle while the output is not stalled and no load is running; the result
//   passes the table read register, then the output register, and can leave from there.
// Load: one memory write per copy actually written, table by table, one write per cycle,
//   no beat taken meanwhile. Clear and unknown commands do not enter the load state.
// Reset (rst_n, synchronous): fill counts, thresholds and category counter go to zero;
//   table contents stay undefined and are only used below the fill counts.
module discrete_table_sampler_core #(
  parameter int CATEGORIES  = dts_pkg::DEF_CATEGORIES,
  parameter int TABLE_DEPTH = dts_pkg::DEF_TABLE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  dts_in_if.sink    in_ch,
  dts_out_if.source out_ch
);
  import dts_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int CW  = $clog2(TABLE_DEPTH + 1);
  localparam int NCW = $clog2(CATEGORIES + 1);
  localparam int TW  = CW + 3 * BYTE_W;
  localparam int MEM_DEPTH = NUM_TABLES << AW;

  typedef enum logic {ST_IDLE, ST_LOAD} state_t;

  state_t             state_r;
  logic [CW-1:0]      cnt_r [NUM_TABLES];
  logic [TW-1:0]      thr_r [NUM_TABLES];
  logic [NCW-1:0]     next_cat_r;
  logic [CAT_W-1:0]   cat_r;
  logic [WORD_W-1:0]  w_r;
  logic [BYTE_W-1:0]  rem_r;
  logic [TBL_W-1:0]   tbl_r;

  logic               s1_v_r;
  logic               s1_oor_r;
  logic [CAT_W-1:0]   rdata_r;
  logic               out_valid_r;
  logic [CAT_W-1:0]   out_cat_r;
  logic               out_oor_r;

  logic [CAT_W-1:0]   mem [MEM_DEPTH];

  logic               s1_adv;
  logic               in_ready;
  logic               in_fire;
  logic               smp_fire;
  logic [TW-1:0]      j_ext;
  logic               smp_oor;
  logic [TBL_W-1:0]   smp_tbl;
  logic [AW-1:0]      smp_idx;
  logic [WORD_W-1:0]  j;
  logic [CW-1:0]      cnt_cur;
  logic               tbl_full;
  logic               load_wr;
  logic [TW-1:0]      dlt;

  assign s1_adv   = s1_v_r && (!out_valid_r || out_ch.ready);
  assign in_ready = (state_r == ST_IDLE) && (!s1_v_r || s1_adv);
  assign in_fire  = in_ch.valid && in_ready;
  assign smp_fire = in_fire && (in_ch.cmd == CMD_SAMPLE);

  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.category     = out_cat_r;
  assign out_ch.out_of_range = out_oor_r;

  // Pick the table by threshold compare; past the last threshold means out of range.
  assign j       = in_ch.random_word;
  assign j_ext   = TW'(j);
  assign smp_oor = (j_ext >= thr_r[3]);

  always_comb begin
    priority if (j_ext < thr_r[0]) begin
      smp_tbl = TBL_W'(0);
      smp_idx = AW'(j >> (3 * BYTE_W));
    end else if (j_ext < thr_r[1]) begin
      smp_tbl = TBL_W'(1);
      smp_idx = AW'((j - thr_r[0][WORD_W-1:0]) >> (2 * BYTE_W));
    end else if (j_ext < thr_r[2]) begin
      smp_tbl = TBL_W'(2);
      smp_idx = AW'((j - thr_r[1][WORD_W-1:0]) >> BYTE_W);
    end else begin
      smp_tbl = TBL_W'(3);
      smp_idx = AW'(j - thr_r[2][WORD_W-1:0]);
    end
  end

  assign cnt_cur  = cnt_r[tbl_r];
  assign tbl_full = (cnt_cur == CW'(TABLE_DEPTH));
  assign load_wr  = (state_r == ST_LOAD) && (rem_r != '0) && !tbl_full;

  // Threshold step for one more entry in the current table.
  always_comb begin
    unique case (tbl_r)
      TBL_W'(0): dlt = TW'(1) << (3 * BYTE_W);
      TBL_W'(1): dlt = TW'(1) << (2 * BYTE_W);
      TBL_W'(2): dlt = TW'(1) << BYTE_W;
      default:   dlt = TW'(1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_wr) begin
      mem[{tbl_r, cnt_cur[AW-1:0]}] <= cat_r;
    end
    if (smp_fire) begin
      rdata_r <= mem[{smp_tbl, smp_idx}];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_cat_r  <= '0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_TABLES; i++) begin
        cnt_r[i] <= '0;
        thr_r[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        out_valid_r <= 1'b1;
        out_oor_r   <= s1_oor_r;
        out_cat_r   <= s1_oor_r ? '0 : rdata_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (smp_fire) begin
        s1_v_r   <= 1'b1;
        s1_oor_r <= smp_oor;
      end else if (s1_adv) begin
        s1_v_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            case (in_ch.cmd)
              CMD_CLEAR: begin
                next_cat_r <= '0;
                for (int i = 0; i < NUM_TABLES; i++) begin
                  cnt_r[i] <= '0;
                  thr_r[i] <= '0;
                end
              end
              CMD_LOAD: begin
                // drop loads once every category is taken
                if (next_cat_r != NCW'(CATEGORIES)) begin
                  next_cat_r <= next_cat_r + NCW'(1);
                  cat_r      <= CAT_W'(next_cat_r);
                  rem_r      <= in_ch.weight[WORD_W-1 -: BYTE_W];
                  w_r        <= in_ch.weight << BYTE_W;
                  tbl_r      <= '0;
                  state_r    <= ST_LOAD;
                end
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          if (load_wr) begin
            cnt_r[tbl_r] <= cnt_cur + CW'(1);
            rem_r        <= rem_r - BYTE_W'(1);
            for (int i = 0; i < NUM_TABLES; i++) begin
              if (TBL_W'(i) >= tbl_r) begin
                thr_r[i] <= thr_r[i] + dlt;
              end
            end
          end else if (tbl_r == TBL_W'(NUM_TABLES - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            // advance to the next table with the next weight byte
            tbl_r <= tbl_r + TBL_W'(1);
            rem_r <= w_r[WORD_W-1 -: BYTE_W];
            w_r   <= w_r << BYTE_W;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_no_beat_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> !in_fire)
    else $error("beat accepted during table load");

  a_oor_cat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (out_cat_r == '0))
    else $error("out of range sample with nonzero category");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    load_wr |=> (cnt_r[$past(tbl_r)] <= CW'(TABLE_DEPTH)))
    else $error("fill count past table depth");

  a_thr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (thr_r[0] <= thr_r[1]) && (thr_r[1] <= thr_r[2]) && (thr_r[2] <= thr_r[3]))
    else $error("thresholds out of order");

endmodule

// ===== test/dts_checker.sv =====
// Checker for the four-table discrete sampler: mirrors the tables from accepted command beats,
// predicts each sample beat and compares it with what comes out.
// Depends on dts_pkg and the channel interfaces in dts_if.
module dts_checker #(
  parameter int CATEGORIES  = dts_pkg::DEF_CATEGORIES,
  parameter int TABLE_DEPTH = dts_pkg::DEF_TABLE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  dts_in_if    in_ch,
  dts_out_if   out_ch,
  output int   errors,
  output int   pending,
  output int   draws_checked,
  output int   misses_seen,
  output int   loads_taken,
  output int   clears_taken
);
  timeunit 1ns;
  timeprecision 1ps;
  import dts_pkg::*;

  typedef struct packed {
    logic [CAT_W-1:0] category;
    logic             out_of_range;
  } draw_t;

  logic [CAT_W-1:0] tab [NUM_TABLES][TABLE_DEPTH];
  int unsigned      fill [NUM_TABLES];
  int unsigned      cats_loaded;
  draw_t            expected_draws [$];

  // Append one category: byte k of the weight gives the copies for table k.
  function automatic void append_category(logic [WORD_W-1:0] w);
    int unsigned copies;
    if (cats_loaded >= CATEGORIES) return;
    for (int k = 0; k < NUM_TABLES; k++) begin
      copies = w[WORD_W-1-BYTE_W*k -: BYTE_W];
      for (int unsigned i = 0; i < copies && fill[k] < TABLE_DEPTH; i++) begin
        tab[k][fill[k]] = cats_loaded[CAT_W-1:0];
        fill[k]++;
      end
    end
    cats_loaded++;
  endfunction

  function automatic draw_t draw_from_tables(logic [WORD_W-1:0] j);
    longint unsigned t0, t1, t2, jj, idx;
    int              sel;
    draw_t           d;
    t0 = 64'(fill[0]) << 24;
    t1 = t0 + (64'(fill[1]) << 16);
    t2 = t1 + (64'(fill[2]) << 8);
    jj = 64'(j);
    if (jj < t0) begin
      sel = 0;
      idx = jj >> 24;
    end else if (jj < t1) begin
      sel = 1;
      idx = (jj - t0) >> 16;
    end else if (jj < t2) begin
      sel = 2;
      idx = (jj - t1) >> 8;
    end else begin
      sel = 3;
      idx = jj - t2;
    end
    if (idx < 64'(fill[sel])) begin
      d.category     = tab[sel][idx];
      d.out_of_range = 1'b0;
    end else begin
      d.category     = '0;
      d.out_of_range = 1'b1;
    end
    return d;
  endfunction

  always @(posedge clk) begin
    draw_t got, want;
    if (!rst_n) begin
      fill        = '{default: 0};
      cats_loaded = 0;
      expected_draws.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.category     = out_ch.category;
        got.out_of_range = out_ch.out_of_range;
        if (expected_draws.size() == 0) begin
          $error("sample beat with no draw pending: category %0d, out_of_range %0b",
                 got.category, got.out_of_range);
          errors++;
        end else begin
          want = expected_draws.pop_front();
          draws_checked++;
          if (want.out_of_range) misses_seen++;
          if (got.category !== want.category) begin
            $error("category: expected %0d, actual %0d", want.category, got.category);
            errors++;
          end
          if (got.out_of_range !== want.out_of_range) begin
            $error("out_of_range: expected %0b, actual %0b", want.out_of_range,
                   got.out_of_range);
            errors++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.cmd)
          CMD_CLEAR: begin
            fill        = '{default: 0};
            cats_loaded = 0;
            clears_taken++;
          end
          CMD_LOAD: begin
            append_category(in_ch.weight);
            loads_taken++;
          end
          CMD_SAMPLE: expected_draws = {expected_draws, draw_from_tables(in_ch.random_word)};
          default: ;
        endcase
      end
    end
    pending = expected_draws.size();
  end

endmodule

// ===== test/tb.sv =====
// Top of the discrete sampler testbench: clock, reset, command and sample stimulus,
// output stalls and the verdict. Depends on dts_pkg, dts_if, the core and dts_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dts_pkg::*;

  localparam int CATEGORIES   = DEF_CATEGORIES;
  localparam int TABLE_DEPTH  = DEF_TABLE_DEPTH;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int ITEM_GOAL    = 1300;
  localparam int HOLD_CYCLES  = 300;
  // a load can write up to 4*255 entries
  localparam int DRAIN_CYCLES = 1100;
  // ~300 loads at their longest plus every sample behind the worst stalls, taken several times
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam longint unsigned FULL_SCALE = 64'h1_0000_0000;

  typedef enum int {SPLIT_UNIT, ANY_WEIGHT, LOW_BYTES, TOP_BYTE} weight_mix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  dts_in_if  in_ch ();
  dts_out_if out_ch ();

  int errors, pending, draws_checked, misses_seen, loads_taken, clears_taken;
  int cycle_count;
  int beats;
  bit quiet;
  bit hold_req;
  int unsigned sh_fill [NUM_TABLES];
  int unsigned sh_cats;

  discrete_table_sampler_core #(
    .CATEGORIES (CATEGORIES),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  dts_checker #(
    .CATEGORIES (CATEGORIES),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) draw_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .errors       (errors),
    .pending      (pending),
    .draws_checked(draws_checked),
    .misses_seen  (misses_seen),
    .loads_taken  (loads_taken),
    .clears_taken (clears_taken)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  always @(posedge clk) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $error("timed out after %0d cycles with %0d draws pending", cycle_count, pending);
    $display("FAIL");
    $finish;
  end

  // Offer one beat, wait for it to be taken, and track the fill counts to aim samples.
  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [WORD_W-1:0] w,
                           input logic [WORD_W-1:0] j);
    int unsigned sum;
    quiet = beats >= 500 && beats < 760;
    while (!quiet && $urandom_range(99) < 26) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.weight      <= w;
    in_ch.random_word <= j;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (c != CMD_UNUSED) beats++;
    if (c == CMD_CLEAR) begin
      sh_fill = '{default: 0};
      sh_cats = 0;
    end else if (c == CMD_LOAD && sh_cats < CATEGORIES) begin
      for (int k = 0; k < NUM_TABLES; k++) begin
        sum = sh_fill[k] + w[WORD_W-1-BYTE_W*k -: BYTE_W];
        sh_fill[k] = sum > TABLE_DEPTH ? TABLE_DEPTH : sum;
      end
      sh_cats++;
    end
  endtask

  // Word value where the tables before table k stop covering the range.
  function automatic longint unsigned fill_edge(int k);
    longint unsigned t;
    t = 0;
    for (int i = 0; i < k; i++) t += 64'(sh_fill[i]) << (24 - 8 * i);
    return t;
  endfunction

  function automatic logic [WORD_W-1:0] near_edge_word();
    longint unsigned t;
    t = fill_edge($urandom_range(1, NUM_TABLES)) + $urandom_range(0, 2);
    if (t == 0 || t > FULL_SCALE) return $urandom;
    return WORD_W'(t - 1);
  endfunction

  // Clear if asked, load a set of categories, then draw from them with some noise mixed in.
  task automatic run_set(int n_cats, weight_mix_t mix, int n_draws, bit clear_first);
    longint unsigned rem, share;
    logic [WORD_W-1:0] w;
    int roll;
    if (clear_first) send_beat(CMD_CLEAR, $urandom, $urandom);
    rem = FULL_SCALE;
    for (int i = 0; i < n_cats; i++) begin
      case (mix)
        SPLIT_UNIT: begin
          if (i == n_cats - 1) share = rem;
          else share = rem * $urandom_range(0, 2000 / (n_cats - i)) / 1000;
          if (share > rem) share = rem;
          if (share > 64'hFFFF_FFFF) share = 64'hFFFF_FFFF;
          rem -= share;
          w = share[WORD_W-1:0];
        end
        ANY_WEIGHT: w = $urandom;
        LOW_BYTES:  w = $urandom_range(0, 16'hFFFF);
        default:    w = $urandom & 32'hFF00_0000;
      endcase
      send_beat(CMD_LOAD, w, $urandom);
    end
    // stall the output once while a burst of samples is offered
    if (!hold_req && beats > 250) hold_req = 1'b1;
    for (int i = 0; i < n_draws; i++) begin
      roll = $urandom_range(99);
      if (roll < 4) send_beat(CMD_UNUSED, $urandom, $urandom);
      else if (roll < 7) send_beat(CMD_LOAD, $urandom, $urandom);
      else if (roll < 42) send_beat(CMD_SAMPLE, $urandom, near_edge_word());
      else send_beat(CMD_SAMPLE, $urandom, $urandom);
    end
  endtask

  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ch.ready <= quiet || $urandom_range(99) >= 26;
    end
  end

  initial begin
    int set_no;
    int roll;
    weight_mix_t mix;
    in_ch.valid       = 1'b0;
    in_ch.cmd         = CMD_CLEAR;
    in_ch.weight      = '0;
    in_ch.random_word = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // empty tables: every word lands past the filled entries
    send_beat(CMD_SAMPLE, 32'h0, 32'h0);
    send_beat(CMD_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_beat(CMD_CLEAR, 32'h0, 32'h0);
    // zero weight, then entries in all four tables
    send_beat(CMD_LOAD, 32'h0, 32'h0);
    send_beat(CMD_LOAD, 32'h40FF_FFFF, 32'h0);
    send_beat(CMD_LOAD, 32'h0101_0101, 32'h0);
    send_beat(CMD_SAMPLE, 32'h0, 32'h0);
    for (int k = 1; k <= NUM_TABLES; k++) begin
      send_beat(CMD_SAMPLE, 32'h0, WORD_W'(fill_edge(k) - 1));
      send_beat(CMD_SAMPLE, 32'h0, WORD_W'(fill_edge(k)));
    end
    send_beat(CMD_SAMPLE, 32'h0, 32'hFFFF_FFFF);
    // largest weight: the tables cover all but the very last word
    send_beat(CMD_CLEAR, 32'h0, 32'h0);
    send_beat(CMD_LOAD, 32'hFFFF_FFFF, 32'h0);
    send_beat(CMD_SAMPLE, 32'h0, 32'hFFFF_FFFF);
    send_beat(CMD_SAMPLE, 32'h0, 32'hFEFF_FFFF);

    set_no = 0;
    while (beats < ITEM_GOAL) begin
      roll = $urandom_range(99);
      mix  = roll < 50 ? SPLIT_UNIT : roll < 70 ? ANY_WEIGHT : roll < 85 ? LOW_BYTES : TOP_BYTE;
      if (set_no == 2) begin
        // run past the category limit so the extra loads are dropped
        run_set(CATEGORIES + 4, SPLIT_UNIT, 40, 1'b1);
      end else begin
        run_set($urandom_range(0, 9) == 0 ? $urandom_range(17, 40) : $urandom_range(2, 16),
                mix, $urandom_range(30, 110), $urandom_range(0, 9) != 0);
      end
      set_no++;
    end
    in_ch.valid <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d samples (%0d past the filled entries) across %0d loads and %0d clears,",
             draws_checked, misses_seen, loads_taken, clears_taken);
    $display("including reserved commands, category overflow and one long output stall.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
